// ===== rtl/hamming_dictionary_match_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dictionary-match engine
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HAMMING_DICTIONARY_MATCH_ASSERT_SVH
`define HAMMING_DICTIONARY_MATCH_ASSERT_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define HDM_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: same-cycle check failed");

// Whenever cond holds, prop must hold in the following cycle.
`define HDM_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/hdm_pkg.sv =====
// ----------------------------------------------------------------------------
// hdm_pkg
// Shared constants and types of the dictionary-match engine.
// ----------------------------------------------------------------------------
package hdm_pkg;

    // Word format: up to twelve 5-bit letter codes, position 0 in the low bits.
    localparam int LETTER_BITS = 5;
    localparam int WORD_W      = 60;
    localparam int LEN_W       = 4;
    localparam int CMD_W       = 2;

    // Default sizes handed to the top level.
    localparam int DEF_DICT_DEPTH  = 64;
    localparam int DEF_MAX_LETTERS = 12;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_WORD_LENGTH = 1'b0;
    localparam logic CFG_MAX_EDITS   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] RST_WORD_LENGTH = 4'd12;
    localparam logic [LEN_W-1:0] RST_MAX_EDITS   = 4'd2;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Query token that travels from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [WORD_W-1:0] word;
    } token_t;

endpackage

// ===== rtl/hamming_dictionary_match.sv =====
// ----------------------------------------------------------------------------
// hamming_dictionary_match
// Dictionary-match engine: loads, clears and Hamming-distance queries over a
// row of dictionary cells.
// ----------------------------------------------------------------------------
// Each dictionary word sits in its own cell of a row of DICT_DEPTH cells. A
// load or clear transaction answers in the cycle after it is accepted. A
// query enters the first cell and moves one cell per clock; the hit flag
// leaving the last cell is registered in ST_SCAN and handed to the result
// register in ST_DONE. One item is in the block at a time; the next is taken
// once the result register is free or being drained. There is no clearing
// pass after reset. Configuration writes take effect at once and belong in idle time.
`include "hamming_dictionary_match_assert.svh"

module hamming_dictionary_match
    import hdm_pkg::*;
#(
    parameter int DICT_DEPTH  = DEF_DICT_DEPTH,
    parameter int MAX_LETTERS = DEF_MAX_LETTERS
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // [59:0] word, [63:60] zero
    input  logic [CMD_W-1:0] s_tuser,   // [1:0] cmd
    // Result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] matched, [7:1] zero
    output logic             m_tuser,   // [0] status
    // Configuration write port
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [LEN_W-1:0] cfg_wdata
);

    localparam int COUNT_W = $clog2(DICT_DEPTH + 1);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic               matched_reg, matched_next;
    logic               status_reg, status_next;
    logic               hit_reg, hit_next;
    logic [LEN_W-1:0]   word_length_reg;
    logic [LEN_W-1:0]   max_edits_reg;
    logic [LEN_W-1:0]   len_eff;
    logic               in_fire;
    logic               out_free;
    logic               full;
    logic               load_ok;
    token_t             chain [DICT_DEPTH+1];

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign full     = (count_reg == COUNT_W'(DICT_DEPTH));
    assign load_ok  = in_fire && (s_tuser == CMD_LOAD) && !full;

    // Word lengths beyond the letter count saturate.
    assign len_eff = (word_length_reg > LEN_W'(MAX_LETTERS)) ?
                     LEN_W'(MAX_LETTERS) : word_length_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= RST_WORD_LENGTH;
            max_edits_reg   <= RST_MAX_EDITS;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_WORD_LENGTH)
            begin
                word_length_reg <= cfg_wdata;
            end
            else
            begin
                max_edits_reg <= cfg_wdata;
            end
        end
    end

    // Query token injected into the first cell.
    assign chain[0].valid = in_fire && (s_tuser == CMD_QUERY);
    assign chain[0].hit   = 1'b0;
    assign chain[0].word  = s_tdata[WORD_W-1:0];

    // Row of dictionary cells.
    for (genvar i = 0; i < DICT_DEPTH; i++)
    begin : g_cell
        hdm_cell #(
            .MAX_LETTERS (MAX_LETTERS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .active    (COUNT_W'(i) < count_reg),
            .wr_en     (load_ok && (count_reg == COUNT_W'(i))),
            .wr_word   (s_tdata[WORD_W-1:0]),
            .len       (len_eff),
            .max_edits (max_edits_reg),
            .tok_in    (chain[i]),
            .tok_out   (chain[i+1])
        );
    end

    // Sequencer: next state, entry count and result register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        matched_next   = matched_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == CMD_QUERY)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        matched_next   = 1'b0;
                        status_next    = 1'b0;
                        if (s_tuser == CMD_LOAD)
                        begin
                            if (full)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else if (s_tuser == CMD_CLEAR)
                        begin
                            count_next = '0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (chain[DICT_DEPTH].valid)
                begin
                    hit_next   = chain[DICT_DEPTH].hit;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    matched_next   = hit_reg;
                    status_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        status_reg  <= status_next;
        hit_reg     <= hit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, matched_reg};
    assign m_tuser  = status_reg;

    // Checks on the sequencer and the cell row.
    `HDM_ASSERT_IMPLY(a_count_range, 1'b1, count_reg <= COUNT_W'(DICT_DEPTH))
    `HDM_ASSERT_IMPLY(a_tail_in_scan, chain[DICT_DEPTH].valid, state_reg == ST_SCAN)
    `HDM_ASSERT_NEXT(a_query_scans, in_fire && (s_tuser == CMD_QUERY), state_reg == ST_SCAN)
    `HDM_ASSERT_IMPLY(a_reject_no_match, out_valid_reg && status_reg, !matched_reg)

endmodule

// ===== rtl/hdm_cell.sv =====
// ----------------------------------------------------------------------------
// hdm_cell
// One dictionary slot: holds a stored word, compares the passing query token
// with it and hands the token, with its accumulated hit flag, to the next cell.
// ----------------------------------------------------------------------------
module hdm_cell
    import hdm_pkg::*;
#(
    parameter int MAX_LETTERS = DEF_MAX_LETTERS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             active,     // slot holds a valid word
    input  logic             wr_en,      // load the word into this slot
    input  logic [WORD_W-1:0] wr_word,
    input  logic [LEN_W-1:0] len,        // letters compared, already saturated
    input  logic [LEN_W-1:0] max_edits,
    input  token_t           tok_in,
    output token_t           tok_out
);

    logic [WORD_W-1:0]      store_reg;
    logic [MAX_LETTERS-1:0] mismatch;
    logic [LEN_W-1:0]       diff_cnt;
    logic                   close;
    logic                   valid_reg;
    logic                   hit_reg;
    logic [WORD_W-1:0]      word_reg;

    // Stored word of this slot.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg <= wr_word;
        end
    end

    // Per-letter mismatch flags over the compared positions.
    always_comb
    begin
        for (int pos = 0; pos < MAX_LETTERS; pos++)
        begin
            mismatch[pos] = (LEN_W'(pos) < len) &&
                (store_reg[pos*LETTER_BITS +: LETTER_BITS] !=
                 tok_in.word[pos*LETTER_BITS +: LETTER_BITS]);
        end
    end

    // Count the differing letters and test against the edit budget.
    assign diff_cnt = LEN_W'($countones(mismatch));
    assign close    = active && (diff_cnt <= max_edits);

    // Token valid bit is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    // Token payload moves on to the neighbor every cycle.
    always_ff @(posedge clk)
    begin
        hit_reg  <= tok_in.hit || close;
        word_reg <= tok_in.word;
    end

    assign tok_out.valid = valid_reg;
    assign tok_out.hit   = hit_reg;
    assign tok_out.word  = word_reg;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Dictionary-match engine testbench
// Drives load, query, clear and unused-command transactions into
// hamming_dictionary_match under several word_length and max_edits settings.
// A built-in predictor tracks the stored words and the registers and works
// out the matched and status answer of every accepted item. A monitor
// compares each result transaction with the oldest predicted answer. Both
// stream sides idle and stall at random, except in the final traffic phase.
// ----------------------------------------------------------------------------
module testbench
    import hdm_pkg::*;
();

    localparam int DEPTH   = DEF_DICT_DEPTH;
    localparam int LETTERS = DEF_MAX_LETTERS;

    // Command code that the block has no use for.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [WORD_W-1:0] ALL_ONES = 60'hFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic matched;
        logic status;
    } answer_t;

    // Clock, reset and block ports.
    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [63:0]      s_tdata;   // [59:0] word, [63:60] zero
    logic [CMD_W-1:0] s_tuser;   // [1:0] cmd
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // [0] matched, [7:1] zero
    logic             m_tuser;   // [0] status
    logic             cfg_we;
    logic             cfg_addr;
    logic [LEN_W-1:0] cfg_wdata;

    // Predictor state: stored words, fill level and register copies.
    logic [WORD_W-1:0] dict_words [DEPTH];
    int                dict_used;
    logic [LEN_W-1:0]  cur_word_len;
    logic [LEN_W-1:0]  cur_max_edits;

    // Answers predicted but not yet seen on the result stream.
    answer_t pending_answers [$];
    answer_t head_answer;

    // Bookkeeping.
    int  error_count;
    int  items_sent;
    int  query_count;
    int  hit_count;
    int  refused_loads;
    int  settings_used;
    bit  idling_on;
    int  stall_left;

    hamming_dictionary_match DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock with a period of 12 units.
    always #6 clk = ~clk;

    // Number of letter positions in which two words differ, over the first len.
    function automatic int letter_distance(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                           int len);
        int p;
        int diffs;
        diffs = 0;
        for (p = 0; p < len; p++)
        begin
            if (a[p*LETTER_BITS +: LETTER_BITS] != b[p*LETTER_BITS +: LETTER_BITS])
                diffs++;
        end
        return diffs;
    endfunction

    // Apply one item to the predictor state and return the answer it causes.
    function automatic answer_t predict_answer(logic [CMD_W-1:0] cmd,
                                               logic [WORD_W-1:0] word);
        answer_t ans;
        int      len;
        int      i;
        ans = '0;
        case (cmd)
            CMD_LOAD:
            begin
                if (dict_used < DEPTH)
                begin
                    dict_words[dict_used] = word;
                    dict_used++;
                end
                else
                begin
                    ans.status = 1'b1;
                end
            end
            CMD_QUERY:
            begin
                // Lengths above the letter count saturate.
                len = (int'(cur_word_len) > LETTERS) ? LETTERS : int'(cur_word_len);
                for (i = 0; i < dict_used; i++)
                begin
                    if (letter_distance(word, dict_words[i], len) <= int'(cur_max_edits))
                        ans.matched = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                dict_used = 0;
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[WORD_W-1:0];
    endfunction

    // Copy of a word with up to nchg letters replaced by different codes.
    function automatic logic [WORD_W-1:0] mutate_word(logic [WORD_W-1:0] base, int nchg);
        logic [WORD_W-1:0] w;
        int                j;
        int                p;
        w = base;
        for (j = 0; j < nchg; j++)
        begin
            p = $urandom_range(0, LETTERS - 1);
            w[p*LETTER_BITS +: LETTER_BITS] =
                w[p*LETTER_BITS +: LETTER_BITS] ^ 5'($urandom_range(1, 31));
        end
        return w;
    endfunction

    // Send one item; the answer is predicted at the accepting edge.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, word};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        pending_answers.insert(pending_answers.size(), predict_answer(cmd, word));
        items_sent++;
        if (cmd == CMD_QUERY)
            query_count++;
    endtask

    // Hold off the sender until every predicted answer has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, issued only while the block is idle.
    task automatic write_register(input logic idx, input logic [LEN_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WORD_LENGTH)
            cur_word_len = value;
        else
            cur_max_edits = value;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] edits);
        write_register(CFG_WORD_LENGTH, len);
        write_register(CFG_MAX_EDITS, edits);
        settings_used++;
    endtask

    // Mixed traffic; most queries sit close to a stored word.
    task automatic run_mixed_traffic(input int n_items);
        int                k;
        int                pick;
        logic [WORD_W-1:0] w;
        for (k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_item(CMD_LOAD, random_word());
            end
            else if (pick < 92)
            begin
                if (dict_used > 0 && $urandom_range(0, 3) != 0)
                    w = mutate_word(dict_words[$urandom_range(0, dict_used - 1)],
                                    $urandom_range(0, 4));
                else
                    w = random_word();
                send_item(CMD_QUERY, w);
            end
            else if (pick < 97)
            begin
                send_item(CMD_CLEAR, random_word());
            end
            else
            begin
                send_item(CMD_UNUSED, random_word());
            end
        end
    endtask

    // Extremes of the fields, every command and the special register values.
    task automatic test_directed();
        logic [WORD_W-1:0] w;
        w = 60'h123_4567_89AB_CDEF;
        send_item(CMD_QUERY, '0);                          // empty store
        send_item(CMD_LOAD, '0);
        send_item(CMD_LOAD, ALL_ONES);
        send_item(CMD_QUERY, '0);                          // exact hit
        send_item(CMD_QUERY, {5'h1F, 50'b0, 5'h1F});       // two letters off
        send_item(CMD_QUERY, {5'h1F, 45'b0, 5'h1F, 5'h1F}); // three letters off
        send_item(CMD_UNUSED, ALL_ONES);
        send_item(CMD_QUERY, {12{5'd26}});                 // codes above the alphabet
        send_item(CMD_QUERY, {6{5'd31, 5'd27}});
        send_item(CMD_CLEAR, ALL_ONES);
        send_item(CMD_QUERY, '0);                          // empty after clear
        // Zero length compares nothing, so any query hits a non-empty store.
        apply_setting(4'd0, 4'd0);
        send_item(CMD_LOAD, w);
        send_item(CMD_QUERY, ~w);
        // Saturating length and an edit limit that accepts everything.
        apply_setting(4'd15, 4'd15);
        send_item(CMD_QUERY, ~w);
        // Only the lowest letter counts.
        apply_setting(4'd1, 4'd0);
        send_item(CMD_QUERY, {~w[WORD_W-1:LETTER_BITS], w[LETTER_BITS-1:0]});
        send_item(CMD_QUERY, {w[WORD_W-1:LETTER_BITS], ~w[LETTER_BITS-1:0]});
        // Full length with exact match required, then the edit limits at the top.
        apply_setting(4'd12, 4'd0);
        send_item(CMD_QUERY, w);
        send_item(CMD_QUERY, mutate_word(w, 1));
        apply_setting(4'd12, 4'd12);
        send_item(CMD_QUERY, ~w);
        apply_setting(4'd12, 4'd11);
        send_item(CMD_QUERY, ~w);
        apply_setting(RST_WORD_LENGTH, RST_MAX_EDITS);
    endtask

    // Fill the store to the top, push loads past it and query across it.
    task automatic test_full_store();
        int k;
        send_item(CMD_CLEAR, '0);
        for (k = 0; k < DEPTH; k++)
            send_item(CMD_LOAD, random_word());
        for (k = 0; k < 3; k++)
            send_item(CMD_LOAD, random_word());
        send_item(CMD_QUERY, dict_words[0]);
        send_item(CMD_QUERY, mutate_word(dict_words[DEPTH - 1], 2));
        for (k = 0; k < 30; k++)
            send_item(CMD_QUERY, mutate_word(dict_words[$urandom_range(0, DEPTH - 1)],
                                             $urandom_range(0, 5)));
        send_item(CMD_CLEAR, '0);
        send_item(CMD_LOAD, ALL_ONES);
        send_item(CMD_QUERY, ALL_ONES);
    endtask

    // Random traffic under a range of register settings.
    task automatic test_setting_sweep();
        apply_setting(4'd1, 4'd0);
        run_mixed_traffic(100);
        apply_setting(4'd12, 4'd0);
        run_mixed_traffic(100);
        apply_setting(4'd6, 4'd1);
        run_mixed_traffic(100);
        apply_setting(4'd12, 4'd3);
        run_mixed_traffic(100);
        apply_setting(4'd13, 4'd2);
        run_mixed_traffic(100);
        apply_setting(4'd0, 4'd0);
        run_mixed_traffic(60);
        apply_setting(4'd9, 4'd12);
        run_mixed_traffic(80);
        apply_setting(4'd12, 4'd11);
        run_mixed_traffic(80);
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_full_rate();
        apply_setting(4'($urandom_range(1, 12)), 4'($urandom_range(0, 4)));
        idling_on = 1'b0;
        run_mixed_traffic(200);
    endtask

    // Result-side ready with random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest predicted answer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected result: matched %0b status %0b",
                             m_tdata[0], m_tuser);
            end
            else
            begin
                head_answer = pending_answers.pop_front();
                if (head_answer.matched !== m_tdata[0] || head_answer.status !== m_tuser)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Mismatch: expected matched %0b status %0b, got %0b %0b",
                                 head_answer.matched, head_answer.status,
                                 m_tdata[0], m_tuser);
                end
                else if (head_answer.matched)
                begin
                    hit_count++;
                end
                if (head_answer.status === 1'b1)
                    refused_loads++;
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #8_000_000;
        $display("Timeout with %0d answers outstanding", pending_answers.size());
        $display("status: fail");
        $finish;
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_LOAD;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_WORD_LENGTH;
        cfg_wdata     = '0;
        dict_used     = 0;
        cur_word_len  = RST_WORD_LENGTH;
        cur_max_edits = RST_MAX_EDITS;
        error_count   = 0;
        items_sent    = 0;
        query_count   = 0;
        hit_count     = 0;
        refused_loads = 0;
        settings_used = 0;
        stall_left    = 0;
        idling_on     = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_setting_sweep();
        test_full_rate();

        drain_results();
        repeat (DEPTH + 8) @(posedge clk);
        error_count += pending_answers.size();

        $display("Sent %0d items, %0d of them queries with %0d hits; %0d loads refused.",
                 items_sent, query_count, hit_count, refused_loads);
        $display("Ran %0d register settings, including zero and saturating lengths.",
                 settings_used);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
